/* hdl/ihs_pkg.sv */
// Shared types, codes and constants of the integer hash set engine.
// Depends on nothing; every module of the engine imports it.
package ihs_pkg;

  // Prime capacity table and the bucket index width it implies.
  localparam int PRIME_COUNT      = 9;
  localparam int MAX_BUCKETS      = 1543;
  localparam int BKT_W            = 11;
  localparam int LEVEL_W          = 4;
  localparam int COUNT_W          = 11;
  localparam int DEF_LEVELS       = 8;
  localparam int DEF_NODES        = 2048;
  localparam int DEF_ELEMENT_BITS = 64;

  // Command codes.
  localparam logic [2:0] CMD_PUT        = 3'd0;
  localparam logic [2:0] CMD_CLEAR      = 3'd1;
  localparam logic [2:0] CMD_ITER_START = 3'd2;
  localparam logic [2:0] CMD_ITER_NEXT  = 3'd3;
  localparam logic [2:0] CMD_REMOVE     = 3'd4;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] element;
  } in_item_t;

  typedef struct packed {
    logic [63:0]        current_element;
    logic               has_current;
    logic               added;
    logic               refused;
    logic [COUNT_W-1:0] count;
  } out_item_t;

  typedef enum logic [4:0] {
    S_RST_CLR, S_IDLE, S_MOD,
    S_PUT_HRD, S_PUT_HWT, S_PUT_WALK, S_PUT_CMP, S_PUT_CHK,
    S_ALLOC, S_ALLOC_W, S_INS_HRD, S_INS_WR,
    S_G_CLR, S_G_BKT, S_G_BWT, S_G_NODE, S_G_NWT, S_G_IDX, S_G_LNK,
    S_CLR, S_SCAN, S_SCAN_W, S_NEXT_W,
    S_RM_NX, S_RM_HD, S_RM_WALK, S_RM_PW, S_RM_FREE,
    S_OUT, S_DONE
  } state_t;

  // Prime capacity of a level; levels past the table stay at the last prime.
  function automatic logic [BKT_W-1:0] prime_of(input logic [LEVEL_W-1:0] lvl);
    logic [BKT_W-1:0] p;
    case (lvl)
      4'd0:    p = 11'd3;
      4'd1:    p = 11'd11;
      4'd2:    p = 11'd23;
      4'd3:    p = 11'd53;
      4'd4:    p = 11'd97;
      4'd5:    p = 11'd193;
      4'd6:    p = 11'd389;
      4'd7:    p = 11'd769;
      default: p = 11'd1543;
    endcase
    return p;
  endfunction

endpackage

/* hdl/integer_hash_set_engine.sv */
// Top level of the integer hash set engine: command FSM, bit-serial modulo
// unit and the bucket, value and link memories. Depends on ihs_pkg.
//
// A command is taken when start is high and busy is low; exactly one result
// follows on out_item with a one-cycle out_valid strobe, and the receiver
// cannot stall it. Command time is set by the bit-serial modulo unit (one
// element bit per cycle) and by the single read port of each memory, which
// is read once per chain node visited. A put computes the bucket index and
// walks its chain; a put that grows the table first empties the spare bucket
// bank, then moves the chain of each old bucket into it, recomputing the
// bucket index of every stored element, and then recomputes the index of
// the new element. Clear sweeps the current capacity, one bucket a cycle.
// Iteration start scans the buckets for the first occupied one. Next follows
// the link of the current node and scans the buckets when the chain ends.
// Remove walks the chain to the predecessor and scans the buckets when the
// chain ends. Next or remove without a current element, and unused command
// codes, go straight to the result.
// After reset the block stays busy while the first bucket bank is emptied.
module integer_hash_set_engine
  import ihs_pkg::*;
#(
  parameter int LEVELS       = DEF_LEVELS,
  parameter int NODES        = DEF_NODES,
  parameter int ELEMENT_BITS = DEF_ELEMENT_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int NA   = $clog2(NODES);
  localparam int NW   = NA + 1;
  localparam int EB   = ELEMENT_BITS;
  localparam int MCW  = $clog2(EB + 1);
  localparam int TOP  = (LEVELS < PRIME_COUNT - 1) ? LEVELS : PRIME_COUNT - 1;
  localparam int HA   = BKT_W + 1;
  localparam logic [NW-1:0] NIL = NW'(NODES);

  // Control and datapath registers.
  state_t             state_r, state_nxt, mod_ret_r, mod_ret_nxt;
  logic               bank_r, bank_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [NW-1:0]      free_r, free_nxt, pool_r, pool_nxt;
  logic [NW-1:0]      iter_n_r, iter_n_nxt, n_r, n_nxt, nx_r, nx_nxt;
  logic [BKT_W-1:0]   iter_b_r, iter_b_nxt, idx_r, idx_nxt, i_r, i_nxt;
  logic [BKT_W-1:0]   rem_r, rem_nxt, mod_p_r, mod_p_nxt;
  logic [EB-1:0]      e_r, e_nxt, mval_r, mval_nxt;
  logic [MCW-1:0]     mcnt_r, mcnt_nxt;
  logic               added_r, added_nxt, refused_r, refused_nxt;

  // Memory ports.
  logic [NW-1:0] heads_mem [2**HA];
  logic [EB-1:0] vals_mem  [NODES];
  logic [NW-1:0] links_mem [NODES];
  logic [HA-1:0] hd_raddr, hd_waddr;
  logic          hd_we;
  logic [NW-1:0] hd_wdata, hd_rd_r;
  logic [NA-1:0] nd_raddr, nd_waddr;
  logic          lk_we, vl_we;
  logic [NW-1:0] lk_wdata, lnk_rd_r;
  logic [EB-1:0] val_rd_r;

  // Derived conditions.
  logic [BKT_W-1:0] cap, newc;
  logic [BKT_W:0]   t_mod, t_sub;
  logic [BKT_W-1:0] r_new;
  logic             cnt_over, top_full, pool_dry;

  assign cap      = prime_of(level_r);
  assign newc     = prime_of(level_r + 4'd1);
  assign t_mod    = {rem_r, mval_r[EB-1]};
  assign t_sub    = t_mod - {1'b0, mod_p_r};
  assign r_new    = (t_mod >= {1'b0, mod_p_r}) ? t_sub[BKT_W-1:0] : t_mod[BKT_W-1:0];
  assign cnt_over = ({1'b0, count_r} + 12'd1) > {1'b0, cap};
  assign top_full = cnt_over && (level_r >= LEVEL_W'(TOP));
  assign pool_dry = (free_r == NIL) && (pool_r >= NIL);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_RST_CLR:  if (i_r == cap - 11'd1) state_nxt = S_IDLE;
      S_IDLE: begin
        if (start) begin
          case (in_item.cmd)
            CMD_PUT:        state_nxt = S_MOD;
            CMD_CLEAR:      state_nxt = S_CLR;
            CMD_ITER_START: state_nxt = S_SCAN;
            CMD_ITER_NEXT:  state_nxt = (iter_n_r == NIL) ? S_OUT : S_NEXT_W;
            CMD_REMOVE:     state_nxt = (iter_n_r == NIL) ? S_OUT : S_RM_NX;
            default:        state_nxt = S_OUT;
          endcase
        end
      end
      S_MOD:      if (mcnt_r == MCW'(1)) state_nxt = mod_ret_r;
      S_PUT_HRD:  state_nxt = S_PUT_HWT;
      S_PUT_HWT:  state_nxt = S_PUT_WALK;
      S_PUT_WALK: state_nxt = (n_r == NIL) ? S_PUT_CHK : S_PUT_CMP;
      S_PUT_CMP:  state_nxt = (val_rd_r == e_r) ? S_OUT : S_PUT_WALK;
      S_PUT_CHK: begin
        if (top_full || pool_dry) state_nxt = S_OUT;
        else if (cnt_over)        state_nxt = S_G_CLR;
        else                      state_nxt = S_ALLOC;
      end
      S_ALLOC:    state_nxt = (free_r != NIL) ? S_ALLOC_W : S_INS_HRD;
      S_ALLOC_W:  state_nxt = S_INS_HRD;
      S_INS_HRD:  state_nxt = S_INS_WR;
      S_INS_WR:   state_nxt = S_OUT;
      S_G_CLR:    if (i_r == newc - 11'd1) state_nxt = S_G_BKT;
      S_G_BKT:    state_nxt = S_G_BWT;
      S_G_BWT:    state_nxt = S_G_NODE;
      S_G_NODE: begin
        if (n_r != NIL)               state_nxt = S_G_NWT;
        else if (i_r == cap - 11'd1)  state_nxt = S_MOD;
        else                          state_nxt = S_G_BKT;
      end
      S_G_NWT:    state_nxt = S_MOD;
      S_G_IDX:    state_nxt = S_G_LNK;
      S_G_LNK:    state_nxt = S_G_NODE;
      S_CLR:      if (i_r == cap - 11'd1) state_nxt = S_OUT;
      S_SCAN:     state_nxt = (i_r >= cap) ? S_OUT : S_SCAN_W;
      S_SCAN_W:   state_nxt = (hd_rd_r != NIL) ? S_OUT : S_SCAN;
      S_NEXT_W:   state_nxt = (lnk_rd_r != NIL) ? S_OUT : S_SCAN;
      S_RM_NX:    state_nxt = S_RM_HD;
      S_RM_HD:    state_nxt = (hd_rd_r == iter_n_r) ? S_RM_FREE : S_RM_WALK;
      S_RM_WALK:  state_nxt = (n_r == NIL) ? S_OUT : S_RM_PW;
      S_RM_PW:    state_nxt = (lnk_rd_r == iter_n_r) ? S_RM_FREE : S_RM_WALK;
      S_RM_FREE:  state_nxt = (nx_r != NIL) ? S_OUT : S_SCAN;
      S_OUT:      state_nxt = S_DONE;
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Datapath next values and memory controls.
  always_comb begin
    mod_ret_nxt = mod_ret_r;
    bank_nxt    = bank_r;
    level_nxt   = level_r;
    count_nxt   = count_r;
    free_nxt    = free_r;
    pool_nxt    = pool_r;
    iter_n_nxt  = iter_n_r;
    iter_b_nxt  = iter_b_r;
    n_nxt       = n_r;
    nx_nxt      = nx_r;
    idx_nxt     = idx_r;
    i_nxt       = i_r;
    rem_nxt     = rem_r;
    mod_p_nxt   = mod_p_r;
    e_nxt       = e_r;
    mval_nxt    = mval_r;
    mcnt_nxt    = mcnt_r;
    added_nxt   = added_r;
    refused_nxt = refused_r;
    hd_raddr    = '0;
    hd_we       = 1'b0;
    hd_waddr    = '0;
    hd_wdata    = NIL;
    nd_raddr    = '0;
    nd_waddr    = n_r[NA-1:0];
    lk_we       = 1'b0;
    lk_wdata    = hd_rd_r;
    vl_we       = 1'b0;
    case (state_r) inside
      // Empty the active bank up to the current capacity.
      S_RST_CLR, S_CLR: begin
        hd_we    = 1'b1;
        hd_waddr = {bank_r, i_r};
        i_nxt    = i_r + 11'd1;
      end
      // Command transfer.
      S_IDLE: begin
        if (start) begin
          added_nxt   = 1'b0;
          refused_nxt = 1'b0;
          e_nxt       = in_item.element[EB-1:0];
          case (in_item.cmd) inside
            CMD_PUT: begin
              iter_n_nxt  = NIL;
              mval_nxt    = in_item.element[EB-1:0];
              rem_nxt     = '0;
              mcnt_nxt    = MCW'(EB);
              mod_p_nxt   = cap;
              mod_ret_nxt = S_PUT_HRD;
            end
            CMD_CLEAR: begin
              i_nxt      = '0;
              free_nxt   = NIL;
              pool_nxt   = '0;
              count_nxt  = '0;
              iter_n_nxt = NIL;
            end
            CMD_ITER_START: i_nxt = '0;
            CMD_ITER_NEXT, CMD_REMOVE: nd_raddr = iter_n_r[NA-1:0];
            default: ;
          endcase
        end
      end
      // One remainder bit per cycle.
      S_MOD: begin
        rem_nxt  = r_new;
        idx_nxt  = r_new;
        mval_nxt = mval_r << 1;
        mcnt_nxt = mcnt_r - MCW'(1);
      end
      S_PUT_HRD:  hd_raddr = {bank_r, idx_r};
      S_PUT_HWT:  n_nxt = hd_rd_r;
      S_PUT_WALK: nd_raddr = n_r[NA-1:0];
      S_PUT_CMP:  n_nxt = lnk_rd_r;
      S_PUT_CHK: begin
        if (top_full || pool_dry) refused_nxt = 1'b1;
        i_nxt = '0;
      end
      // Take a node from the free list, else from the unused pool.
      S_ALLOC: begin
        if (free_r != NIL) begin
          n_nxt    = free_r;
          nd_raddr = free_r[NA-1:0];
        end else begin
          n_nxt    = pool_r;
          pool_nxt = pool_r + NW'(1);
        end
      end
      S_ALLOC_W:  free_nxt = lnk_rd_r;
      S_INS_HRD:  hd_raddr = {bank_r, idx_r};
      S_INS_WR: begin
        vl_we     = 1'b1;
        lk_we     = 1'b1;
        lk_wdata  = hd_rd_r;
        hd_we     = 1'b1;
        hd_waddr  = {bank_r, idx_r};
        hd_wdata  = n_r;
        count_nxt = count_r + 11'd1;
        added_nxt = 1'b1;
      end
      // Growth: empty the spare bank, then move every chain into it.
      S_G_CLR: begin
        hd_we    = 1'b1;
        hd_waddr = {~bank_r, i_r};
        i_nxt    = (i_r == newc - 11'd1) ? '0 : i_r + 11'd1;
      end
      S_G_BKT:    hd_raddr = {bank_r, i_r};
      S_G_BWT:    n_nxt = hd_rd_r;
      S_G_NODE: begin
        if (n_r != NIL) begin
          nd_raddr = n_r[NA-1:0];
        end else if (i_r == cap - 11'd1) begin
          bank_nxt    = ~bank_r;
          level_nxt   = level_r + 4'd1;
          mval_nxt    = e_r;
          rem_nxt     = '0;
          mcnt_nxt    = MCW'(EB);
          mod_p_nxt   = newc;
          mod_ret_nxt = S_ALLOC;
        end else begin
          i_nxt = i_r + 11'd1;
        end
      end
      S_G_NWT: begin
        nx_nxt      = lnk_rd_r;
        mval_nxt    = val_rd_r;
        rem_nxt     = '0;
        mcnt_nxt    = MCW'(EB);
        mod_p_nxt   = newc;
        mod_ret_nxt = S_G_IDX;
      end
      S_G_IDX:    hd_raddr = {~bank_r, idx_r};
      S_G_LNK: begin
        lk_we    = 1'b1;
        lk_wdata = hd_rd_r;
        hd_we    = 1'b1;
        hd_waddr = {~bank_r, idx_r};
        hd_wdata = n_r;
        n_nxt    = nx_r;
      end
      // Bucket scan for the iterator.
      S_SCAN: begin
        if (i_r < cap) hd_raddr = {bank_r, i_r};
        else           iter_n_nxt = NIL;
      end
      S_SCAN_W: begin
        if (hd_rd_r != NIL) begin
          iter_b_nxt = i_r;
          iter_n_nxt = hd_rd_r;
        end else begin
          i_nxt = i_r + 11'd1;
        end
      end
      S_NEXT_W: begin
        if (lnk_rd_r != NIL) iter_n_nxt = lnk_rd_r;
        else                 i_nxt = iter_b_r + 11'd1;
      end
      // Unlink the current node from its chain.
      S_RM_NX: begin
        nx_nxt   = lnk_rd_r;
        hd_raddr = {bank_r, iter_b_r};
      end
      S_RM_HD: begin
        if (hd_rd_r == iter_n_r) begin
          hd_we    = 1'b1;
          hd_waddr = {bank_r, iter_b_r};
          hd_wdata = nx_r;
        end else begin
          n_nxt = hd_rd_r;
        end
      end
      S_RM_WALK: begin
        if (n_r == NIL) iter_n_nxt = NIL;
        else            nd_raddr = n_r[NA-1:0];
      end
      S_RM_PW: begin
        if (lnk_rd_r == iter_n_r) begin
          lk_we    = 1'b1;
          lk_wdata = nx_r;
        end else begin
          n_nxt = lnk_rd_r;
        end
      end
      S_RM_FREE: begin
        lk_we    = 1'b1;
        nd_waddr = iter_n_r[NA-1:0];
        lk_wdata = free_r;
        free_nxt = iter_n_r;
        if (count_r != '0) count_nxt = count_r - 11'd1;
        if (nx_r != NIL) iter_n_nxt = nx_r;
        else             i_nxt = iter_b_r + 11'd1;
      end
      S_OUT:      nd_raddr = iter_n_r[NA-1:0];
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_RST_CLR;
      mod_ret_r <= S_IDLE;
      bank_r    <= 1'b0;
      level_r   <= '0;
      count_r   <= '0;
      free_r    <= NIL;
      pool_r    <= '0;
      iter_n_r  <= NIL;
      iter_b_r  <= '0;
      i_r       <= '0;
      mcnt_r    <= '0;
      added_r   <= 1'b0;
      refused_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      mod_ret_r <= mod_ret_nxt;
      bank_r    <= bank_nxt;
      level_r   <= level_nxt;
      count_r   <= count_nxt;
      free_r    <= free_nxt;
      pool_r    <= pool_nxt;
      iter_n_r  <= iter_n_nxt;
      iter_b_r  <= iter_b_nxt;
      i_r       <= i_nxt;
      mcnt_r    <= mcnt_nxt;
      added_r   <= added_nxt;
      refused_r <= refused_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    nx_r    <= nx_nxt;
    idx_r   <= idx_nxt;
    rem_r   <= rem_nxt;
    mod_p_r <= mod_p_nxt;
    e_r     <= e_nxt;
    mval_r  <= mval_nxt;
  end

  // Bucket head memory: two banks, the spare one receives a rehash.
  always_ff @(posedge clk) begin
    if (hd_we) heads_mem[hd_waddr] <= hd_wdata;
    hd_rd_r <= heads_mem[hd_raddr];
  end

  // Node value and link memories share the read address.
  always_ff @(posedge clk) begin
    if (vl_we) vals_mem[nd_waddr] <= e_r;
    val_rd_r <= vals_mem[nd_raddr];
  end

  always_ff @(posedge clk) begin
    if (lk_we) links_mem[nd_waddr] <= lk_wdata;
    lnk_rd_r <= links_mem[nd_raddr];
  end

  // Result transfer.
  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);
  always_comb begin
    out_item.has_current     = (iter_n_r != NIL);
    out_item.current_element = (iter_n_r != NIL) ? 64'(val_rd_r) : 64'd0;
    out_item.added           = added_r;
    out_item.refused         = refused_r;
    out_item.count           = count_r;
  end

endmodule

/* tb/ihs_checker.sv */
// Checker for the integer hash set engine: watches command and result
// transfers, predicts each result with its own hash set model and compares.
// Depends on ihs_pkg.
module ihs_checker
  import ihs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOP_LEVEL = (DEF_LEVELS < PRIME_COUNT - 1) ? DEF_LEVELS : PRIME_COUNT - 1;
  localparam int POOL = DEF_NODES;
  localparam int NONE = POOL;

  int unsigned chain_head [MAX_BUCKETS];
  int unsigned spare_head [MAX_BUCKETS];
  logic [63:0] node_val [POOL];
  int unsigned node_nxt [POOL];
  int unsigned free_list, watermark, held, level, walk_bucket, walk_node;
  out_item_t   expected_results [$];

  function automatic int unsigned capacity(int unsigned lvl);
    case (lvl)
      0: return 3;
      1: return 11;
      2: return 23;
      3: return 53;
      4: return 97;
      5: return 193;
      6: return 389;
      7: return 769;
      default: return 1543;
    endcase
  endfunction

  // Point the walk at the first occupied bucket from b on.
  function automatic void seek(int unsigned b);
    int unsigned cap;
    cap = capacity(level);
    while (b < cap) begin
      if (chain_head[b] != NONE) begin
        walk_bucket = b;
        walk_node = chain_head[b];
        return;
      end
      b++;
    end
    walk_node = NONE;
  endfunction

  function automatic void empty_set();
    for (int i = 0; i < MAX_BUCKETS; i++) chain_head[i] = NONE;
    free_list = NONE;
    watermark = 0;
    held = 0;
    walk_node = NONE;
  endfunction

  // Move every chain to the next prime, walking buckets in index order.
  function automatic void rehash();
    int unsigned oldc, newc, n, nx, idx;
    oldc = capacity(level);
    newc = capacity(level + 1);
    for (int i = 0; i < newc; i++) spare_head[i] = NONE;
    for (int i = 0; i < oldc; i++) begin
      n = chain_head[i];
      while (n < POOL) begin
        nx = node_nxt[n];
        idx = 32'(node_val[n] % 64'(newc));
        node_nxt[n] = spare_head[idx];
        spare_head[idx] = n;
        n = nx;
      end
    end
    for (int i = 0; i < newc; i++) chain_head[i] = spare_head[i];
    level++;
  endfunction

  function automatic void insert(logic [63:0] e, ref out_item_t r);
    int unsigned idx, n;
    idx = 32'(e % 64'(capacity(level)));
    n = chain_head[idx];
    walk_node = NONE;
    while (n < POOL) begin
      if (node_val[n] == e) return;
      n = node_nxt[n];
    end
    if ((held + 1 > capacity(level) && level >= TOP_LEVEL) ||
        (free_list == NONE && watermark >= POOL)) begin
      r.refused = 1'b1;
      return;
    end
    if (held + 1 > capacity(level)) begin
      rehash();
      idx = 32'(e % 64'(capacity(level)));
    end
    if (free_list != NONE) begin
      n = free_list;
      free_list = node_nxt[n];
    end else begin
      n = watermark++;
    end
    node_val[n] = e;
    node_nxt[n] = chain_head[idx];
    chain_head[idx] = n;
    held++;
    r.added = 1'b1;
  endfunction

  function automatic void drop_current();
    int unsigned cur, b, nx, p;
    cur = walk_node;
    b = walk_bucket;
    if (cur >= POOL) return;
    nx = node_nxt[cur];
    if (chain_head[b] == cur) begin
      chain_head[b] = nx;
    end else begin
      p = chain_head[b];
      while (p < POOL && node_nxt[p] != cur) p = node_nxt[p];
      if (p >= POOL) begin
        walk_node = NONE;
        return;
      end
      node_nxt[p] = nx;
    end
    node_nxt[cur] = free_list;
    free_list = cur;
    if (held > 0) held--;
    if (nx != NONE) walk_node = nx;
    else seek(b + 1);
  endfunction

  function automatic out_item_t apply_command(in_item_t c);
    out_item_t r;
    r = '0;
    case (c.cmd)
      CMD_PUT:        insert(c.element, r);
      CMD_CLEAR:      empty_set();
      CMD_ITER_START: seek(0);
      CMD_ITER_NEXT: begin
        if (walk_node < POOL) begin
          if (node_nxt[walk_node] != NONE) walk_node = node_nxt[walk_node];
          else seek(walk_bucket + 1);
        end
      end
      CMD_REMOVE:     drop_current();
      default: ;
    endcase
    if (walk_node < POOL) begin
      r.current_element = node_val[walk_node];
      r.has_current = 1'b1;
    end
    r.count = COUNT_W'(held);
    return r;
  endfunction

  assign pending = expected_results.size();

  // Predict on command transfers, compare on result transfers.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      level = 0;
      walk_bucket = 0;
      empty_set();
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (out_item !== want) begin
            fail_count <= fail_count + 1;
            if (out_item.current_element !== want.current_element)
              $error("current_element expected %h got %h", want.current_element,
                     out_item.current_element);
            if (out_item.has_current !== want.has_current)
              $error("has_current expected %b got %b", want.has_current,
                     out_item.has_current);
            if (out_item.added !== want.added)
              $error("added expected %b got %b", want.added, out_item.added);
            if (out_item.refused !== want.refused)
              $error("refused expected %b got %b", want.refused, out_item.refused);
            if (out_item.count !== want.count)
              $error("count expected %0d got %0d", want.count, out_item.count);
          end
        end
      end
      if (start && !busy) expected_results.push_back(apply_command(in_item));
    end
  end
endmodule

/* tb/tb.sv */
// Testbench top for the integer hash set engine: clock, reset, command
// stimulus and verdict. Depends on ihs_pkg, ihs_checker and the engine.
module tb;
  import ihs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic      clk, rst_n, start, busy, out_valid;
  in_item_t  in_item;
  out_item_t out_item;
  int        fail_count, pending;
  int        idle_pct;
  longint    cycles;
  logic [63:0] recent [$];

  integer_hash_set_engine uut (.*);
  ihs_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Global cycle limit.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 3_000_000) begin
        $display("integer_hash_set_engine verification failed");
        $finish;
      end
    end
  end

  // One command transfer, with a random sender gap first.
  task automatic send(logic [2:0] c, logic [63:0] e);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    start <= 1'b1;
    in_item <= '{cmd: c, element: e};
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    // Drop start before the next transfer, which is then driven in a later time step.
    @(posedge clk);
  endtask

  function automatic logic [63:0] pick_value();
    case ($urandom_range(9))
      0: return {$urandom, $urandom};
      1: return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(3);
      2: return recent.size() ? recent[$urandom_range(recent.size() - 1)] : 64'd5;
      default: return 64'($urandom_range(4000));
    endcase
  endfunction

  // Random mix biased toward filling the set and walking it.
  task automatic random_phase(int n);
    logic [2:0]  c;
    logic [63:0] v;
    int          r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 55) c = CMD_PUT;
      else if (r < 57) c = CMD_CLEAR;
      else if (r < 65) c = CMD_ITER_START;
      else if (r < 82) c = CMD_ITER_NEXT;
      else if (r < 97) c = CMD_REMOVE;
      else c = 3'($urandom_range(5, 7));
      v = pick_value();
      if (c == CMD_PUT) recent.push_back(v);
      send(c, c == CMD_PUT ? v : {$urandom, $urandom});
    end
  endtask

  initial begin
    start = 1'b0;
    in_item = '0;
    idle_pct = 0;
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty walks, extremes, duplicates, growth, removal, clear.
    send(CMD_ITER_NEXT, '0);
    send(CMD_REMOVE, '0);
    send(CMD_ITER_START, '0);
    send(CMD_PUT, 64'd0);
    send(CMD_PUT, 64'hFFFF_FFFF_FFFF_FFFF);
    send(CMD_PUT, 64'd3);
    send(CMD_PUT, 64'd0);
    send(CMD_PUT, 64'd6);
    send(CMD_PUT, 64'h5555_5555_5555_5555);
    send(CMD_PUT, 64'hAAAA_AAAA_AAAA_AAAA);
    send(CMD_ITER_START, '0);
    send(CMD_ITER_NEXT, '0);
    send(CMD_REMOVE, '0);
    send(CMD_PUT, 64'd7);
    send(CMD_REMOVE, '0);
    send(CMD_ITER_START, '0);
    for (int i = 0; i < 6; i++) send(CMD_REMOVE, '0);
    send(3'd5, '1);
    send(3'd7, '0);
    send(CMD_CLEAR, '0);
    send(CMD_ITER_START, '0);

    idle_pct = 20;
    random_phase(155);
    idle_pct = 72;
    random_phase(155);
    idle_pct = 0;
    random_phase(155);
    // Walk and empty part of whatever the random phases left behind.
    send(CMD_ITER_START, '0);
    for (int i = 0; i < 20; i++) send(CMD_REMOVE, '0);
    send(CMD_PUT, 64'hFFFF_FFFF_FFFF_FFFE);

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("integer_hash_set_engine verification clean");
    else $display("integer_hash_set_engine verification failed");
    $finish;
  end
endmodule

/* files.f */
hdl/ihs_pkg.sv
hdl/integer_hash_set_engine.sv
tb/ihs_checker.sv
tb/tb.sv
